// ===== rtl/core/ws2812_spi_bit_encoder_macros.svh =====
// ----------------------------------------------------------------------------
// ws2812 spi bit encoder assertion macros
// concurrent checks on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef WS2812_SPI_BIT_ENCODER_MACROS_SVH
`define WS2812_SPI_BIT_ENCODER_MACROS_SVH

// same-cycle implication
`define WSE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ws2812 encoder check failed");

// next-cycle implication
`define WSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ws2812 encoder check failed");

`endif

// ===== rtl/core/wse_pkg.sv =====
// ----------------------------------------------------------------------------
// wse_pkg
// shared constants, types and helpers of the ws2812 spi bit encoder
// ----------------------------------------------------------------------------
`default_nettype none

package wse_pkg;

	localparam int RUN_BYTES = 24;
	localparam int CNT_W     = $clog2(RUN_BYTES);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_BYTES - 1);

	localparam logic [2:0] RST_BRIGHTNESS = 3'd0;
	localparam logic [7:0] RST_ZERO_PAT   = 8'hC0;
	localparam logic [7:0] RST_ONE_PAT    = 8'hF8;

	// input opcode carried in tuser
	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_BLANK = 1'b1;

	// configuration register indexes
	localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
	localparam logic [1:0] REG_ZERO_PAT   = 2'd1;
	localparam logic [1:0] REG_ONE_PAT    = 2'd2;

	// one pending output byte, from the serializer to the output register
	typedef struct packed {
		logic blank;
		logic data_bit;
		logic last;
	} wse_req_t;

	// brightness scaling, bits pushed past bit 7 are dropped
	function automatic logic [7:0] scale_chan(input logic [7:0] c, input logic [2:0] sh);
		return c << sh;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/wse_load.sv =====
// ----------------------------------------------------------------------------
// wse_load
// item register and bit serializer: holds the scaled 24-bit color word
// ----------------------------------------------------------------------------
`default_nettype none

module wse_load
	import wse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        in_opcode,
	input  wire logic [7:0]  in_green,
	input  wire logic [7:0]  in_red,
	input  wire logic [7:0]  in_blue,
	input  wire logic [2:0]  shift,
	output logic             req_valid,
	output wse_req_t         req,
	input  wire logic        req_ready
);

	logic             valid_s1;
	logic             blank_s1;
	logic [23:0]      data_s1;
	logic [CNT_W-1:0] cnt_s1;
	logic             adv;
	logic             is_last;

	assign is_last   = (cnt_s1 == CNT_LAST);
	assign adv       = valid_s1 && req_ready;
	assign in_ready  = !valid_s1 || (adv && is_last);
	assign req_valid = valid_s1;

	always_comb begin
		req.blank    = blank_s1;
		req.data_bit = data_s1[23];
		req.last     = is_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cnt_s1   <= '0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
			cnt_s1   <= '0;
		end else if (adv) begin
			valid_s1 <= !is_last;
			cnt_s1   <= is_last ? '0 : cnt_s1 + 1'b1;
		end
	end

	// green goes out first, msb first
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			blank_s1 <= (in_opcode == OP_BLANK);
			data_s1  <= {scale_chan(in_green, shift), scale_chan(in_red, shift),
				scale_chan(in_blue, shift)};
		end else if (adv) begin
			data_s1 <= {data_s1[22:0], 1'b0};
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/wse_emit.sv =====
// ----------------------------------------------------------------------------
// wse_emit
// output register: maps a data bit to its spi pattern byte
// ----------------------------------------------------------------------------
`default_nettype none

module wse_emit
	import wse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	input  wire wse_req_t   req,
	output logic            req_ready,
	input  wire logic [7:0] zero_pat,
	input  wire logic [7:0] one_pat,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [7:0]      out_byte,
	output logic            out_last
);

	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic [7:0] byte_d;

	assign req_ready = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;

	always_comb begin
		if (req.blank) begin
			byte_d = 8'h00;
		end else if (req.data_bit) begin
			byte_d = one_pat;
		end else begin
			byte_d = zero_pat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (req_ready) begin
			valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			byte_q <= byte_d;
			last_q <= req.last;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/ws2812_spi_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// ws2812_spi_bit_encoder
// turns pixel colors into ws2812 spi pattern bytes, 24 per pixel
// ----------------------------------------------------------------------------
// Each input transaction is one LED slot: a pixel (tuser 0) with green, red
// and blue, or a blank slot (tuser 1). A pixel is scaled by a left shift of
// brightness_shift on each channel (truncated to 8 bits) and sent as 24 spi
// bytes, green then red then blue, msb first, each data bit becoming the one
// or zero pattern byte. A blank slot sends 24 zero bytes; one per LED makes
// the reset gap ahead of a frame. tlast marks the 24th byte of every run.
// Output runs at one byte per cycle while m_tready is high; the 24-step bit
// serializer steps through each slot. The next slot is taken in the cycle its
// predecessor's last byte enters the output register, so runs follow with
// no gap. The first byte passes the item register and then the output
// register before it is valid on the output. Configuration is a plain write
// port (index 0 shift, 1 zero pattern, 2 one pattern) and must only be
// written while no run is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ws2812_spi_bit_encoder_macros.svh"

module ws2812_spi_bit_encoder
	import wse_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // [7:0] green, [15:8] red, [23:16] blue
	input  wire logic [0:0]  s_tuser,   // [0] opcode
	// output stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,   // [7:0] spi_byte
	output logic             m_tlast,
	// configuration write port
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_wdata
);

	logic [2:0] shift_q;
	logic [7:0] zero_pat_q;
	logic [7:0] one_pat_q;

	logic       req_valid;
	logic       req_ready;
	wse_req_t   req;

	// configuration registers, unknown index is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_q    <= RST_BRIGHTNESS;
			zero_pat_q <= RST_ZERO_PAT;
			one_pat_q  <= RST_ONE_PAT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BRIGHTNESS: shift_q    <= cfg_wdata[2:0];
				REG_ZERO_PAT:   zero_pat_q <= cfg_wdata;
				REG_ONE_PAT:    one_pat_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// item register and serializer
	wse_load u_load (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_opcode (s_tuser[0]),
		.in_green  (s_tdata[7:0]),
		.in_red    (s_tdata[15:8]),
		.in_blue   (s_tdata[23:16]),
		.shift     (shift_q),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready)
	);

	// pattern lookup and output register
	wse_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_ready (req_ready),
		.zero_pat  (zero_pat_q),
		.one_pat   (one_pat_q),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_last  (m_tlast)
	);

	// an accepted transaction always starts a run in the serializer
	`WSE_ASSERT_NEXT(a_accept_starts_run, s_tvalid && s_tready, req_valid)
	// a new transaction is only taken when the serializer is empty or finishing
	`WSE_ASSERT_NOW(a_ready_only_at_end, s_tready && req_valid, req.last && req_ready)
	// blank slot bytes are always zero
	`WSE_ASSERT_NEXT(a_blank_is_zero, req_valid && req_ready && req.blank, m_tdata == 8'h00)

endmodule

`default_nettype wire
